[rtl/adcsrb_pkg.sv]
// Shared types, constants and helpers for the ADC scan and result buffer.
// No dependencies; imported by every module of the block.
package adcsrb_pkg;

    localparam int unsigned BUFFER_WORDS = 16;
    localparam int unsigned SLOT_DEPTH   = 32;

    localparam int unsigned CH_W    = 5;
    localparam int unsigned SLOT_W  = 7;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned OFF_W   = 13;
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned MASK_W  = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INCR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DMA_ON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DMA_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST    = 3'd7;

    // Request codes
    localparam logic REQ_SCAN  = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    // Channels scanned on the second module
    localparam logic [MASK_W-1:0] SECOND_MASK  = 32'h0000_FFFF;
    localparam logic [5:0]        SECOND_LIMIT = 6'd16;

    // Upper buffer half start when splitting
    localparam logic [POS_W-1:0] HALF_BASE = 4'd8;

    typedef struct packed {
        logic              en;
        logic [CH_W-1:0]   addr;
        logic [SLOT_W-1:0] data;
    } t_slot_wr;

    typedef struct packed {
        logic            found;
        logic [CH_W-1:0] ch;
        logic [CH_W-1:0] next_pos;
    } t_scan_res;

    // Index of the lowest set bit; 0 when none is set.
    function automatic logic [CH_W-1:0] lowest_set(input logic [MASK_W-1:0] v);
        logic [CH_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = CH_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/adcsrb_slot_mem.sv]
// Per-channel DMA slot store: 32 x 7 synchronous memory with a registered read.
// Valid flags give reset-to-zero; a same-cycle write is bypassed to the read.
module adcsrb_slot_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [adcsrb_pkg::CH_W-1:0] i_rd_addr,
    input  adcsrb_pkg::t_slot_wr       i_wr,
    output logic [adcsrb_pkg::SLOT_W-1:0] o_rd_data
);
    import adcsrb_pkg::*;

    logic [SLOT_W-1:0]     mem [SLOT_DEPTH];
    logic [SLOT_DEPTH-1:0] r_vld_bits;
    logic [SLOT_W-1:0]     r_rd_raw;
    logic                  r_rd_vld;
    logic                  r_byp;
    logic [SLOT_W-1:0]     r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_raw   <= mem[i_rd_addr];
            r_byp_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_bits <= '0;
            r_rd_vld   <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld_bits[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld_bits[i_rd_addr];
                r_byp    <= i_wr.en && (i_wr.addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : (r_rd_vld ? r_rd_raw : '0);

endmodule

[rtl/adcsrb_scan.sv]
// Rotating priority encoder over the scan mask.
// Uses adcsrb_pkg for widths, the result struct and lowest_set().
module adcsrb_scan #(
    parameter int unsigned NUM_CHANNELS = 32
) (
    input  logic [adcsrb_pkg::MASK_W-1:0] i_mask,
    input  logic                          i_first,
    input  logic [adcsrb_pkg::CH_W-1:0]   i_scan_pos,
    output adcsrb_pkg::t_scan_res         o_res
);
    import adcsrb_pkg::*;

    localparam logic [MASK_W-1:0] FirstMask =
        (NUM_CHANNELS >= 32) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << NUM_CHANNELS) - 64'd1);
    localparam logic [5:0] FirstLimit = 6'(NUM_CHANNELS);

    logic [5:0]        limit;
    logic [MASK_W-1:0] sel;
    logic [5:0]        start_w;
    logic [CH_W-1:0]   start;
    logic [MASK_W-1:0] upper;
    logic [CH_W-1:0]   pick;
    logic [5:0]        pick_inc;

    always_comb begin
        limit   = i_first ? FirstLimit : SECOND_LIMIT;
        sel     = i_mask & (i_first ? FirstMask : SECOND_MASK);
        // scan_pos may sit past a smaller limit; one wrap is enough
        start_w = ({1'b0, i_scan_pos} >= limit) ? ({1'b0, i_scan_pos} - limit)
                                                : {1'b0, i_scan_pos};
        start   = start_w[CH_W-1:0];
        upper   = sel & ({MASK_W{1'b1}} << start);
        pick    = (upper != '0) ? lowest_set(upper) : lowest_set(sel);
        pick_inc = {1'b0, pick} + 6'd1;

        o_res.found    = (sel != '0);
        o_res.ch       = pick;
        o_res.next_pos = (pick_inc == limit) ? '0 : pick_inc[CH_W-1:0];
    end

endmodule

[rtl/adc_scan_and_result_buffer.sv]
// ADC scan-channel picker and result placement engine, top level.
// Depends on adcsrb_pkg, adcsrb_scan and adcsrb_slot_mem.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  request  | in        | i_valid / o_stall  | i_req_type, i_channel, i_sample_value
//  result   | out       | o_valid / i_stall  | o_scan_channel, o_to_dma, o_buffer_slot,
//           |           |                    | o_dma_offset, o_data_out, o_irq_pulse,
//           |           |                    | o_second_half
//  config   | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the result side does not stall; the accept edge
// loads stage 1 and launches the slot read, stage 2 runs the update, and the edge that
// advances the item writes the slot back and loads the result register, raising o_valid.
// A write-to-read bypass in the memory covers back-to-back items on one channel.
// Synchronous active-low reset clears all scalar state and the slot valid flags.
// A stall on a pending result holds both stages; o_stall follows it combinationally.
module adc_scan_and_result_buffer #(
    parameter int unsigned NUM_CHANNELS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request items
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic [adcsrb_pkg::CH_W-1:0]         i_channel,
    input  logic [adcsrb_pkg::DATA_W-1:0]       i_sample_value,
    // result items
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [adcsrb_pkg::CH_W-1:0]         o_scan_channel,
    output logic                                o_to_dma,
    output logic [adcsrb_pkg::POS_W-1:0]        o_buffer_slot,
    output logic [adcsrb_pkg::OFF_W-1:0]        o_dma_offset,
    output logic [adcsrb_pkg::DATA_W-1:0]       o_data_out,
    output logic                                o_irq_pulse,
    output logic                                o_second_half,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [adcsrb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adcsrb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import adcsrb_pkg::*;

    // configuration registers
    logic [4:0]        r_incr;
    logic              r_dma;
    logic              r_split;
    logic              r_order;
    logic [2:0]        r_dlen;
    logic [MASK_W-1:0] r_mask;
    logic [CH_W-1:0]   r_fallback;
    logic              r_first;

    // scalar state
    logic [POS_W-1:0]  r_buf_pos,  n_buf_pos;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [CH_W-1:0]   r_scan_pos, n_scan_pos;
    logic              r_half,     n_half;

    // stage 1: item waiting on its slot read
    logic              r_s1_valid;
    logic              r_s1_req;
    logic [CH_W-1:0]   r_s1_ch;
    logic [DATA_W-1:0] r_s1_val;

    // result register
    logic              r_o_valid;
    logic [CH_W-1:0]   r_o_scan, n_o_scan;
    logic              r_o_dma,  n_o_dma;
    logic [POS_W-1:0]  r_o_slot, n_o_slot;
    logic [OFF_W-1:0]  r_o_off,  n_o_off;
    logic [DATA_W-1:0] r_o_data, n_o_data;
    logic              r_o_irq,  n_o_irq;
    logic              r_o_half, n_o_half;

    logic              advance;
    logic [SLOT_W-1:0] slot_rd;
    t_slot_wr          slot_wr;
    t_scan_res         scan_res;

    logic [4:0]        thr_field;
    logic [CNT_W-1:0]  thr;
    logic [CNT_W-1:0]  cnt_inc;
    logic              boundary;
    logic [SLOT_W-1:0] len_mask;
    logic              is_store;

    // Both stages move together whenever the result register is free or drains.
    assign advance = !r_o_valid || !i_stall;
    assign o_stall = !advance;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_incr     <= '0;
            r_dma      <= 1'b0;
            r_split    <= 1'b0;
            r_order    <= 1'b0;
            r_dlen     <= '0;
            r_mask     <= '0;
            r_fallback <= '0;
            r_first    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INCR:     r_incr     <= i_cfg_data[4:0];
                CFG_DMA_ON:   r_dma      <= i_cfg_data[0];
                CFG_SPLIT:    r_split    <= i_cfg_data[0];
                CFG_ORDER:    r_order    <= i_cfg_data[0];
                CFG_DMA_LEN:  r_dlen     <= i_cfg_data[2:0];
                CFG_MASK:     r_mask     <= i_cfg_data[MASK_W-1:0];
                CFG_FALLBACK: r_fallback <= i_cfg_data[CH_W-1:0];
                CFG_FIRST:    r_first    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- slot memory and scan encoder ----------------
    adcsrb_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (advance),
        .i_rd_addr (i_channel),
        .i_wr      (slot_wr),
        .o_rd_data (slot_rd)
    );

    adcsrb_scan #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_scan (
        .i_mask     (r_mask),
        .i_first    (r_first),
        .i_scan_pos (r_scan_pos),
        .o_res      (scan_res)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_req <= i_req_type;
            r_s1_ch  <= i_channel;
            r_s1_val <= i_sample_value;
        end
    end

    // ---------------- stage 2: update and build the result ----------------
    always_comb begin
        is_store = (r_s1_req == REQ_STORE);

        // Drop the top threshold bit unless first module with DMA.
        thr_field = r_incr;
        if (!(r_first && r_dma)) begin
            thr_field[4] = 1'b0;
        end
        thr      = {1'b0, thr_field} + 6'd1;
        cnt_inc  = r_count + 6'd1;
        boundary = (cnt_inc >= thr);
        len_mask = SLOT_W'((8'd1 << r_dlen) - 8'd1);

        n_buf_pos  = r_buf_pos;
        n_count    = r_count;
        n_scan_pos = r_scan_pos;
        n_half     = r_half;

        slot_wr.en   = 1'b0;
        slot_wr.addr = r_s1_ch;
        slot_wr.data = (slot_rd + 7'd1) & len_mask;

        n_o_scan = '0;
        n_o_dma  = 1'b0;
        n_o_slot = '0;
        n_o_off  = '0;
        n_o_data = '0;
        n_o_irq  = 1'b0;

        if (!is_store) begin
            // Empty mask: answer the fallback channel, keep the scan position.
            if (scan_res.found) begin
                n_o_scan   = scan_res.ch;
                n_scan_pos = scan_res.next_pos;
            end else begin
                n_o_scan = r_fallback;
            end
        end else begin
            n_o_data = r_s1_val;
            if (r_dma) begin
                n_o_dma = 1'b1;
                if (r_order) begin
                    n_o_off = {{(OFF_W-POS_W-1){1'b0}}, r_buf_pos, 1'b0};
                end else begin
                    n_o_off = (OFF_W'(r_s1_ch) << ({1'b0, r_dlen} + 4'd1))
                            + {{(OFF_W-SLOT_W-1){1'b0}}, slot_rd, 1'b0};
                    slot_wr.en = r_s1_valid && advance;
                end
            end else begin
                n_o_slot = r_buf_pos;
            end

            n_buf_pos = r_buf_pos + 4'd1;
            n_count   = cnt_inc;
            if (boundary) begin
                n_count    = '0;
                n_scan_pos = '0;
                if (r_split) begin
                    n_half    = !r_half;
                    n_buf_pos = !r_half ? HALF_BASE : '0;
                end else begin
                    n_buf_pos = '0;
                end
            end
            n_o_irq = r_dma || boundary;
        end
        n_o_half = n_half;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_pos  <= '0;
            r_count    <= '0;
            r_scan_pos <= '0;
            r_half     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (advance) begin
            r_o_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_buf_pos  <= n_buf_pos;
                r_count    <= n_count;
                r_scan_pos <= n_scan_pos;
                r_half     <= n_half;
            end
        end
    end

    // Load the result payload only with a live item; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_o_scan <= n_o_scan;
            r_o_dma  <= n_o_dma;
            r_o_slot <= n_o_slot;
            r_o_off  <= n_o_off;
            r_o_data <= n_o_data;
            r_o_irq  <= n_o_irq;
            r_o_half <= n_o_half;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_scan_channel = r_o_scan;
    assign o_to_dma       = r_o_dma;
    assign o_buffer_slot  = r_o_slot;
    assign o_dma_offset   = r_o_off;
    assign o_data_out     = r_o_data;
    assign o_irq_pulse    = r_o_irq;
    assign o_second_half  = r_o_half;

endmodule

[verif/adc_scan_and_result_buffer_tb.sv]
// Self-checking testbench for adc_scan_and_result_buffer: scan picks and result placement.
// Depends on adcsrb_pkg and the RTL top level; holds a placement scoreboard class and the top.
module adc_scan_and_result_buffer_tb;
    import adcsrb_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]   scan_ch;
        logic              to_dma;
        logic [POS_W-1:0]  slot;
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] data;
        logic              irq;
        logic              half;
    } t_placement;

    typedef struct {
        bit [4:0]  incr;
        bit        dma;
        bit        split;
        bit        order;
        bit [2:0]  dlen;
        bit [31:0] mask;
        bit [4:0]  fallback;
        bit        first;
    } t_adc_setting;

    class placement_ledger;
        // register copy
        bit [4:0]  incr;
        bit        dma;
        bit        split;
        bit        order;
        bit [2:0]  dlen;
        bit [31:0] mask;
        bit [4:0]  fallback;
        bit        first;
        // engine state
        bit [3:0]  buf_pos;
        bit [5:0]  count;
        bit [4:0]  scan_pos;
        bit [6:0]  slot_next [32];
        bit        half;

        t_placement awaited [$];
        int         faults;

        function new();
            incr = '0; dma = 1'b0; split = 1'b0; order = 1'b0;
            dlen = '0; mask = '0; fallback = '0; first = 1'b1;
            buf_pos = '0; count = '0; scan_pos = '0; half = 1'b0;
            foreach (slot_next[i]) slot_next[i] = '0;
            faults = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INCR:     incr = data[4:0];
                CFG_DMA_ON:   dma = data[0];
                CFG_SPLIT:    split = data[0];
                CFG_ORDER:    order = data[0];
                CFG_DMA_LEN:  dlen = data[2:0];
                CFG_MASK:     mask = data;
                CFG_FALLBACK: fallback = data[4:0];
                CFG_FIRST:    first = data[0];
                default: ;
            endcase
        endfunction

        // Rotate from scan_pos to the next selected channel; wrap the start modulo the limit.
        function bit [4:0] next_scan_channel();
            int unsigned limit;
            int unsigned chn;
            bit [31:0]   sel;
            limit = first ? 32 : 16;
            sel = first ? mask : (mask & SECOND_MASK);
            if (sel == 0) return fallback;
            for (int unsigned k = 0; k < limit; k++) begin
                chn = (scan_pos + k) % limit;
                if (sel[chn]) begin
                    scan_pos = 5'((chn + 1) % limit);
                    return chn[4:0];
                end
            end
            return '0;
        endfunction

        function void note_request(logic kind, logic [4:0] chan, logic [15:0] sample);
            t_placement  e;
            int unsigned s;
            int unsigned offset;
            int unsigned thr;
            bit          boundary;
            e = '0;
            if (kind == REQ_SCAN) begin
                e.scan_ch = next_scan_channel();
                e.half = half;
                awaited.push_back(e);
                return;
            end
            e.data = sample;
            if (dma) begin
                e.to_dma = 1'b1;
                if (order) begin
                    offset = buf_pos * 2;
                end else begin
                    s = slot_next[chan];
                    offset = chan * (32'd2 << dlen) + s * 2;
                    slot_next[chan] = 7'((s + 1) & ((32'd1 << dlen) - 1));
                end
                e.off = offset[OFF_W-1:0];
            end else begin
                e.slot = buf_pos;
            end
            buf_pos = buf_pos + 4'd1;
            count = count + 6'd1;
            // bit 4 of the increment only counts on the first module with DMA
            thr = (first && dma) ? incr + 1 : incr[3:0] + 1;
            boundary = (count >= thr);
            if (boundary) begin
                count = '0;
                scan_pos = '0;
                if (split) begin
                    half = !half;
                    buf_pos = half ? HALF_BASE : 4'd0;
                end else begin
                    buf_pos = '0;
                end
            end
            e.irq = dma || boundary;
            e.half = half;
            awaited.push_back(e);
        endfunction

        function string describe(t_placement p);
            return $sformatf("scan=%0d dma=%0d slot=%0d off=%0d data=%h irq=%0d half=%0d",
                             p.scan_ch, p.to_dma, p.slot, p.off, p.data, p.irq, p.half);
        endfunction

        function void check_result(t_placement got);
            t_placement want;
            if (awaited.size() == 0) begin
                faults++;
                if (faults <= 10) $display("unexpected result: %s", describe(got));
                return;
            end
            want = awaited.pop_front();
            if (got !== want) begin
                faults++;
                if (faults <= 10) begin
                    $display("mismatch: expected %s", describe(want));
                    $display("          actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    localparam int CHOKE_CYCLES = 200;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS = 100;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic                  req_type = REQ_SCAN;
    logic [CH_W-1:0]       req_channel = '0;
    logic [DATA_W-1:0]     req_sample = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [CH_W-1:0]       res_scan_channel;
    logic                  res_to_dma;
    logic [POS_W-1:0]      res_buffer_slot;
    logic [OFF_W-1:0]      res_dma_offset;
    logic [DATA_W-1:0]     res_data_out;
    logic                  res_irq_pulse;
    logic                  res_second_half;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    placement_ledger ledger = new();

    // knobs shared by the driver and the stall generator
    bit calm_tail = 1'b0;
    int gap_pct = 10;
    int chokes_asked = 0;

    adc_scan_and_result_buffer dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .o_stall        (req_stall),
        .i_req_type     (req_type),
        .i_channel      (req_channel),
        .i_sample_value (req_sample),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_scan_channel (res_scan_channel),
        .o_to_dma       (res_to_dma),
        .o_buffer_slot  (res_buffer_slot),
        .o_dma_offset   (res_dma_offset),
        .o_data_out     (res_data_out),
        .o_irq_pulse    (res_irq_pulse),
        .o_second_half  (res_second_half),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check every result item taken at an edge with valid high and stall low.
    always @(posedge clk) begin : result_monitor
        t_placement got;
        if (rst_n && res_valid && !res_stall) begin
            got.scan_ch = res_scan_channel;
            got.to_dma  = res_to_dma;
            got.slot    = res_buffer_slot;
            got.off     = res_dma_offset;
            got.data    = res_data_out;
            got.irq     = res_irq_pulse;
            got.half    = res_second_half;
            ledger.check_result(got);
        end
    end

    // Stall the result side: short random bursts, plus one long hold-off when asked.
    initial begin : result_stall_gen
        int chokes_served;
        chokes_served = 0;
        forever begin
            @(posedge clk);
            if (chokes_asked != chokes_served) begin
                chokes_served++;
                res_stall <= 1'b1;
                repeat (CHOKE_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Hard limit on the run time.
    initial begin
        #(12 * 600000);
        $display("FAILURE");
        $finish;
    end

    function automatic t_adc_setting make_setting(bit [4:0] incr, bit dma, bit split,
                                                  bit order, bit [2:0] dlen, bit [31:0] mask,
                                                  bit [4:0] fallback, bit first);
        t_adc_setting s;
        s.incr = incr; s.dma = dma; s.split = split; s.order = order;
        s.dlen = dlen; s.mask = mask; s.fallback = fallback; s.first = first;
        return s;
    endfunction

    function automatic t_adc_setting random_setting();
        t_adc_setting s;
        case ($urandom_range(0, 2))
            0: s.incr = 5'd0;
            1: s.incr = 5'd31;
            default: s.incr = 5'($urandom_range(0, 31));
        endcase
        s.dma = 1'($urandom_range(0, 1));
        s.split = 1'($urandom_range(0, 1));
        s.order = 1'($urandom_range(0, 1));
        s.dlen = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
            0: s.mask = '0;
            1: s.mask = '1;
            2: s.mask = 32'd1 << $urandom_range(0, 31);
            3: s.mask = $urandom & 32'hFFFF_0000;
            default: s.mask = $urandom & $urandom;
        endcase
        s.fallback = 5'($urandom_range(0, 31));
        s.first = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Write one register; fill the unused upper data bits with noise.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val,
                           input int width);
        logic [31:0] data;
        data = (width < 32) ? (($urandom << width) | val) : val;
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        ledger.write_reg(idx, data);
    endtask

    // Write all eight registers back to back; only called while the block is idle.
    task automatic apply_setting(input t_adc_setting s);
        put_reg(CFG_INCR, 32'(s.incr), 5);
        put_reg(CFG_DMA_ON, 32'(s.dma), 1);
        put_reg(CFG_SPLIT, 32'(s.split), 1);
        put_reg(CFG_ORDER, 32'(s.order), 1);
        put_reg(CFG_DMA_LEN, 32'(s.dlen), 3);
        put_reg(CFG_MASK, s.mask, 32);
        put_reg(CFG_FALLBACK, 32'(s.fallback), 5);
        put_reg(CFG_FIRST, 32'(s.first), 1);
        cfg_we <= 1'b0;
    endtask

    // Offer one item and hold it until taken; drop valid only during an idle burst.
    task automatic send_item(input logic kind, input logic [CH_W-1:0] chan,
                             input logic [DATA_W-1:0] sample);
        if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= kind;
        req_channel <= chan;
        req_sample <= sample;
        do begin
            @(posedge clk);
        end while (req_stall);
        ledger.note_request(kind, chan, sample);
    endtask

    // Stop offering and wait for every outstanding result, then let the pipe settle.
    task automatic drain();
        req_valid <= 1'b0;
        while (ledger.awaited.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin : stimulus
        t_adc_setting s;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty mask answers the fallback; bit 4 of the increment dropped without DMA
        apply_setting(make_setting(5'd31, 1'b0, 1'b1, 1'b0, 3'd0, 32'h0, 5'd31, 1'b1));
        send_item(REQ_SCAN, 5'd0, 16'h0000);
        send_item(REQ_STORE, 5'd0, 16'h0000);
        send_item(REQ_STORE, 5'd31, 16'hFFFF);
        drain();

        // park the scan position above 15 on the first module
        apply_setting(make_setting(5'd0, 1'b0, 1'b1, 1'b0, 3'd0, 32'h4000_0000, 5'd0, 1'b1));
        send_item(REQ_SCAN, 5'd0, 16'h0000);
        send_item(REQ_SCAN, 5'd31, 16'hFFFF);
        drain();

        // second module: the search start wraps modulo 16
        apply_setting(make_setting(5'd15, 1'b0, 1'b0, 1'b0, 3'd0, 32'h8000_8001, 5'd5, 1'b0));
        send_item(REQ_SCAN, 5'd0, 16'h1234);
        send_item(REQ_SCAN, 5'd0, 16'h1234);
        repeat (5) send_item(REQ_STORE, 5'($urandom_range(0, 31)), random_sample());
        drain();

        // threshold lowered under the count, split off at the boundary
        apply_setting(make_setting(5'd1, 1'b0, 1'b0, 1'b0, 3'd0, 32'h8000_8001, 5'd5, 1'b0));
        send_item(REQ_STORE, 5'd3, 16'hA5A5);
        send_item(REQ_STORE, 5'd4, 16'h5A5A);
        drain();

        // DMA scatter at the longest length, full threshold
        apply_setting(make_setting(5'd31, 1'b1, 1'b1, 1'b0, 3'd7, 32'hFFFF_FFFF, 5'd0, 1'b1));
        repeat (3) send_item(REQ_STORE, 5'd31, random_sample());
        send_item(REQ_STORE, 5'd0, 16'hFFFF);
        send_item(REQ_SCAN, 5'd0, 16'h0000);
        drain();

        // shorter DMA length: use the old slot as is, wrap on the advance
        apply_setting(make_setting(5'd31, 1'b1, 1'b0, 1'b0, 3'd1, 32'hFFFF_FFFF, 5'd0, 1'b1));
        send_item(REQ_STORE, 5'd31, 16'h0F0F);
        send_item(REQ_STORE, 5'd31, 16'hF0F0);
        drain();

        // conversion order: offset tracks the buffer position
        apply_setting(make_setting(5'd31, 1'b1, 1'b0, 1'b1, 3'd1, 32'hFFFF_FFFF, 5'd0, 1'b1));
        send_item(REQ_STORE, 5'd7, 16'h0001);
        send_item(REQ_STORE, 5'd7, 16'h8000);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm_tail = (p >= RANDOM_PHASES - 2);
            gap_pct = $urandom_range(0, 40);
            if (p == 0)
                s = make_setting(5'd31, 1'b1, 1'b1, 1'b1, 3'd7, 32'hFFFF_FFFF, 5'd31, 1'b1);
            else if (p == 1)
                s = make_setting(5'd0, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0, 5'd0, 1'b0);
            else
                s = random_setting();
            apply_setting(s);
            // hold off the receiver for a long stretch while items keep coming
            if (p == 5) chokes_asked++;
            repeat (PHASE_ITEMS)
                send_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), random_sample());
            drain();
        end

        if (ledger.faults == 0 && ledger.awaited.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
